@@ src/lts_pkg.sv @@
// shared types, constants and lookup functions for the lexical token scanner
`default_nettype none

package lts_pkg;

  // result field widths
  localparam int KIND_W     = 5;
  localparam int LINE_OUT_W = 16;
  localparam int LEN_OUT_W  = 5;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_ID         = 5'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_STRING     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_KW_BASE    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_PUNCT_BASE = 5'd9;
  localparam logic [KIND_W-1:0] KIND_LT         = 5'd21;
  localparam logic [KIND_W-1:0] KIND_LE         = 5'd22;
  localparam logic [KIND_W-1:0] KIND_GT         = 5'd23;
  localparam logic [KIND_W-1:0] KIND_GE         = 5'd24;
  localparam logic [KIND_W-1:0] KIND_EQEQ       = 5'd25;
  localparam logic [KIND_W-1:0] KIND_NE         = 5'd26;
  localparam logic [KIND_W-1:0] KIND_ASSIGN     = 5'd27;
  localparam logic [KIND_W-1:0] KIND_NOT        = 5'd28;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL    = 5'd29;
  localparam logic [KIND_W-1:0] KIND_END        = 5'd30;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // type-name keywords: str int char bool num void
  localparam int NUM_KW = 6;
  localparam logic [7:0] KW_TEXT [NUM_KW][4] = '{
    '{8'h73, 8'h74, 8'h72, 8'h00},
    '{8'h69, 8'h6E, 8'h74, 8'h00},
    '{8'h63, 8'h68, 8'h61, 8'h72},
    '{8'h62, 8'h6F, 8'h6F, 8'h6C},
    '{8'h6E, 8'h75, 8'h6D, 8'h00},
    '{8'h76, 8'h6F, 8'h69, 8'h64}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4};

  // single-character punctuators ; , ( ) [ ] { } + - * /
  localparam int NUM_PUNCT = 12;
  localparam logic [7:0] PUNCT [NUM_PUNCT] = '{
    8'h3B, 8'h2C, 8'h28, 8'h29, 8'h5B, 8'h5D,
    8'h7B, 8'h7D, 8'h2B, 8'h2D, 8'h2A, 8'h2F
  };

  // output queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // first character of a relational operator
  typedef enum logic [1:0] {
    OP_LT   = 2'd0,
    OP_GT   = 2'd1,
    OP_EQ   = 2'd2,
    OP_BANG = 2'd3
  } op_t;

  // one result token
  typedef struct packed {
    logic [KIND_W-1:0]     token_kind;
    logic [LINE_OUT_W-1:0] token_line;
    logic [LEN_OUT_W-1:0]  token_length;
    logic                  too_long;
    logic                  last_of_run;
  } token_t;

  // up to two tokens pushed by one character
  typedef struct packed {
    logic   vld0;
    logic   vld1;
    token_t tok0;
    token_t tok1;
  } push_t;

  // keyword candidates that still agree after char c at position pos
  function automatic logic [NUM_KW-1:0] kw_keep(input logic [2:0] pos, input logic [7:0] c);
    logic [NUM_KW-1:0] keep;
    keep = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      keep[k] = (pos < KW_LEN[k]) && (KW_TEXT[k][pos[1:0]] == c);
    end
    return keep;
  endfunction

  function automatic logic punct_hit(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_PUNCT; k++) begin
      if (PUNCT[k] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] kind;
    kind = KIND_PUNCT_BASE;
    for (int k = 0; k < NUM_PUNCT; k++) begin
      if (PUNCT[k] == c) kind = KIND_PUNCT_BASE + KIND_W'(k);
    end
    return kind;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input op_t op, input logic two);
    logic [KIND_W-1:0] kind;
    case (op)
      OP_LT:   kind = two ? KIND_LE : KIND_LT;
      OP_GT:   kind = two ? KIND_GE : KIND_GT;
      OP_EQ:   kind = two ? KIND_EQEQ : KIND_ASSIGN;
      default: kind = two ? KIND_NE : KIND_NOT;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

@@ src/lts_in_if.sv @@
// character request channel
`default_nettype none

interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ src/lts_out_if.sv @@
// token request channel
`default_nettype none

interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_line;
  logic [4:0]  token_length;
  logic        too_long;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_line, output token_length,
                  output too_long, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_line, input token_length,
                  input too_long, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/lexical_token_scanner_core.sv @@
// Lexical token scanner: one source character per request in, tokens out.
// in_ch carries a character (ch) or an end mark (end_of_input); out_ch carries
// tokens with kind, start line, saturated length, overlong flag and a flag on
// the last token that one character caused. Both channels use valid/ready.
// A character is taken into an input register, scanned once the queue has room
// by the state machine and its keyword matchers, and its zero, one or two
// tokens are written into a four-entry token queue; the first token is valid
// on out_ch from the queue entry that it was written into.
// Throughput is one character per cycle while the queue has room; the queue
// drains one token per cycle while the receiver takes them, so a character
// that yields two tokens costs the output side two pops. The held character
// is scanned only when the queue has room for two tokens; otherwise in_ch.ready
// stays low until the receiver takes tokens. A stalled receiver therefore
// backs up into the queue and then the input.
// Reset (rst_n low, synchronous) empties the queue and puts the scanner
// between tokens on line 1; an end mark flushes any open token (an open
// string as illegal), adds an end token and returns to the same state.
`default_nettype none

module lexical_token_scanner_core import lts_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 30,
  parameter int LINE_BITS     = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch
);

  push_t push;
  logic  room;

  // scanner with input register
  lts_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .LINE_BITS     (LINE_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_ch    (in_ch.ch),
    .in_end   (in_ch.end_of_input),
    .room     (room),
    .push     (push)
  );

  // token queue toward the result channel
  lts_tok_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

  // tokens are only written while the queue has room for two
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld0 |-> room)
    else $error("token written without queue room");

  // the second slot is only used after the first
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld1 |-> push.vld0)
    else $error("second token slot used alone");

  // exactly the final token of a run carries the last flag
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld0 |-> (push.tok0.last_of_run == !push.vld1))
    else $error("last-of-run flag misplaced");

  // an end token always closes its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.token_kind == KIND_END)) |-> out_ch.last_of_run)
    else $error("end token not marked last");

endmodule

`default_nettype wire

@@ src/lts_scan.sv @@
// input register and scanner state machine, produces up to two tokens per character
`default_nettype none

module lts_scan import lts_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 30,
  parameter int LINE_BITS     = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_end,
  input  wire logic       room,
  output push_t           push
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TOKEN_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_FOUR = LEN_W'(4);
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  typedef enum logic [4:0] {
    S_START = 5'b00001,
    S_NUM   = 5'b00010,
    S_ID    = 5'b00100,
    S_OP    = 5'b01000,
    S_STR   = 5'b10000
  } scan_state_t;

  // input register
  logic       item_vld_r;
  logic [7:0] item_ch_r;
  logic       item_end_r;
  logic       process;

  // scanner state
  scan_state_t          state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [NUM_KW-1:0]    kw_r, kw_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [LINE_BITS-1:0] start_r, start_nxt;

  // character classes
  logic c_digit, c_letter, c_ws, c_op, c_quote;

  // pending token flushed when the current token ends
  logic   pend_vld;
  token_t pend_tok;
  logic [KIND_W-1:0] id_kind;

  // extension of the current token by one character
  logic [LEN_W-1:0] ext_len;
  logic             ext_ovf;

  // fresh scan of the character from between tokens
  logic                 st_vld;
  token_t               st_tok;
  scan_state_t          st_state;
  logic                 st_begin;
  op_t                  st_op;
  logic [NUM_KW-1:0]    st_kw;
  logic [LINE_BITS-1:0] st_line;

  // ordered tokens before compaction
  logic   a_vld, b_vld;
  token_t a_tok, b_tok;

  function automatic logic [LINE_OUT_W-1:0] line16(input logic [LINE_BITS-1:0] x);
    logic [LINE_BITS+LINE_OUT_W-1:0] wide;
    wide = {{LINE_OUT_W{1'b0}}, x};
    return wide[LINE_OUT_W-1:0];
  endfunction

  function automatic logic [LEN_OUT_W-1:0] len5(input logic [LEN_W-1:0] x);
    logic [LEN_W+LEN_OUT_W-1:0] wide;
    wide = {{LEN_OUT_W{1'b0}}, x};
    return wide[LEN_OUT_W-1:0];
  endfunction

  function automatic token_t make_tok(input logic [KIND_W-1:0] kind,
                                      input logic [LINE_BITS-1:0] line,
                                      input logic [LEN_OUT_W-1:0] len,
                                      input logic ovf);
    token_t t;
    t.token_kind   = kind;
    t.token_line   = line16(line);
    t.token_length = len;
    t.too_long     = ovf;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // input handshake: a held character leaves once the queue has room for two tokens
  assign process  = item_vld_r && room;
  assign in_ready = !item_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_vld_r <= 1'b1;
    end else if (process) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_ch_r  <= in_ch;
      item_end_r <= in_end;
    end
  end

  // character classes
  always_comb begin
    c_digit  = (item_ch_r >= 8'h30) && (item_ch_r <= 8'h39);
    c_letter = ((item_ch_r >= 8'h61) && (item_ch_r <= 8'h7A)) ||
               ((item_ch_r >= 8'h41) && (item_ch_r <= 8'h5A));
    c_ws     = (item_ch_r == CH_SPACE) || (item_ch_r == CH_TAB) ||
               (item_ch_r == CH_CR) || (item_ch_r == CH_NL);
    c_op     = (item_ch_r == CH_LT) || (item_ch_r == CH_GT) ||
               (item_ch_r == CH_EQ) || (item_ch_r == CH_BANG);
    c_quote  = (item_ch_r == CH_QUOTE);
  end

  // identifier kind: a whole-word keyword match, first one wins
  always_comb begin
    id_kind = KIND_ID;
    if (!ovf_r) begin
      for (int k = NUM_KW - 1; k >= 0; k--) begin
        if (kw_r[k] && (len_r == LEN_W'(KW_LEN[k]))) id_kind = KIND_KW_BASE + KIND_W'(k);
      end
    end
  end

  // token left open by the current state
  always_comb begin
    pend_vld = 1'b1;
    pend_tok = make_tok(KIND_ILLEGAL, start_r, len5(len_r), ovf_r);
    case (state_r)
      S_NUM:   pend_tok = make_tok(KIND_NUMBER, start_r, len5(len_r), ovf_r);
      S_ID:    pend_tok = make_tok(id_kind, start_r, len5(len_r), ovf_r);
      S_OP:    pend_tok = make_tok(op_kind(op_r, 1'b0), start_r, 5'd1, 1'b0);
      S_STR:   pend_tok = make_tok(KIND_ILLEGAL, start_r, len5(len_r), ovf_r);
      default: pend_vld = 1'b0;
    endcase
  end

  // length saturates, overflow sticks
  always_comb begin
    ext_len = (len_r >= LEN_MAX) ? len_r : len_r + LEN_ONE;
    ext_ovf = ovf_r || (len_r >= LEN_MAX);
  end

  // scan from between tokens
  always_comb begin
    st_vld   = 1'b0;
    st_tok   = make_tok(KIND_ILLEGAL, line_r, 5'd1, 1'b0);
    st_state = S_START;
    st_begin = 1'b0;
    st_op    = op_r;
    st_kw    = kw_r;
    st_line  = line_r;
    if (c_ws) begin
      if (item_ch_r == CH_NL) st_line = line_r + LINE_ONE;
    end else if (c_digit) begin
      st_state = S_NUM;
      st_begin = 1'b1;
    end else if (c_letter) begin
      st_state = S_ID;
      st_begin = 1'b1;
      st_kw    = kw_keep(3'd0, item_ch_r);
    end else if (c_op) begin
      st_state = S_OP;
      st_begin = 1'b1;
      if (item_ch_r == CH_LT) st_op = OP_LT;
      else if (item_ch_r == CH_GT) st_op = OP_GT;
      else if (item_ch_r == CH_EQ) st_op = OP_EQ;
      else st_op = OP_BANG;
    end else if (c_quote) begin
      st_state = S_STR;
      st_begin = 1'b1;
    end else if (punct_hit(item_ch_r)) begin
      st_vld = 1'b1;
      st_tok = make_tok(punct_kind(item_ch_r), line_r, 5'd1, 1'b0);
    end else begin
      st_vld = 1'b1;
    end
  end

  // next state and the tokens caused by this character
  always_comb begin
    logic restart;
    logic [2:0] pos;
    restart   = 1'b0;
    pos       = (len_r >= LEN_FOUR) ? 3'd4 : len_r[2:0];
    state_nxt = state_r;
    op_nxt    = op_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    kw_nxt    = kw_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    a_vld     = 1'b0;
    a_tok     = pend_tok;
    b_vld     = 1'b0;
    b_tok     = st_tok;
    if (process) begin
      if (item_end_r) begin
        // flush, end token, back to reset state
        a_vld     = pend_vld;
        b_vld     = 1'b1;
        b_tok     = make_tok(KIND_END, line_r, 5'd0, 1'b0);
        state_nxt = S_START;
        op_nxt    = OP_BANG;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        kw_nxt    = '1;
        line_nxt  = LINE_ONE;
        start_nxt = LINE_ONE;
      end else begin
        case (state_r)
          S_NUM: begin
            if (c_digit) begin
              len_nxt = ext_len;
              ovf_nxt = ext_ovf;
            end else begin
              restart = 1'b1;
            end
          end
          S_ID: begin
            if (c_letter) begin
              kw_nxt  = kw_r & kw_keep(pos, item_ch_r);
              len_nxt = ext_len;
              ovf_nxt = ext_ovf;
            end else begin
              restart = 1'b1;
            end
          end
          S_OP: begin
            if (item_ch_r == CH_EQ) begin
              a_vld     = 1'b1;
              a_tok     = make_tok(op_kind(op_r, 1'b1), start_r, 5'd2, 1'b0);
              state_nxt = S_START;
            end else begin
              restart = 1'b1;
            end
          end
          S_STR: begin
            len_nxt = ext_len;
            ovf_nxt = ext_ovf;
            if (c_quote) begin
              a_vld     = 1'b1;
              a_tok     = make_tok(KIND_STRING, start_r, len5(ext_len), ext_ovf);
              state_nxt = S_START;
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase
        // token ended by this character: flush it, then scan the character afresh
        if (restart) begin
          a_vld     = pend_vld;
          b_vld     = st_vld;
          state_nxt = st_state;
          op_nxt    = st_op;
          kw_nxt    = st_kw;
          line_nxt  = st_line;
          if (st_begin) begin
            len_nxt   = LEN_ONE;
            ovf_nxt   = 1'b0;
            start_nxt = line_r;
          end
        end
      end
    end
  end

  // pack into queue slots and mark the last token of the run
  always_comb begin
    push = '0;
    if (a_vld) begin
      push.vld0 = 1'b1;
      push.tok0 = a_tok;
      push.vld1 = b_vld;
      push.tok1 = b_tok;
    end else begin
      push.vld0 = b_vld;
      push.tok0 = b_tok;
    end
    if (push.vld1) push.tok1.last_of_run = 1'b1;
    else push.tok0.last_of_run = push.vld0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      op_r    <= OP_BANG;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      kw_r    <= '1;
      line_r  <= LINE_ONE;
      start_r <= LINE_ONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      kw_r    <= kw_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/lts_tok_fifo.sv @@
// token queue between the scanner and the result channel, takes up to two tokens a cycle
`default_nettype none

module lts_tok_fifo import lts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  lts_out_if.source  out_ch
);

  localparam logic [FIFO_AW-1:0] PTR_ONE = FIFO_AW'(1);
  localparam logic [FIFO_AW:0]   CNT_ROOM = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  token_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               pop;
  token_t             head;

  // status toward the scanner
  assign room = (cnt_r <= CNT_ROOM);
  assign pop  = out_ch.valid && out_ch.ready;

  // pointer and count update
  always_comb begin
    logic [FIFO_AW:0] n_push;
    n_push     = {{FIFO_AW{1'b0}}, push.vld0} + {{FIFO_AW{1'b0}}, push.vld1};
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_ONE : rd_ptr_r;
    cnt_nxt    = cnt_r + n_push - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.vld0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.vld1) mem_r[wr_ptr_r + PTR_ONE] <= push.tok1;
  end

  // head of queue drives the result channel
  assign head                = mem_r[rd_ptr_r];
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.token_line   = head.token_line;
  assign out_ch.token_length = head.token_length;
  assign out_ch.too_long     = head.too_long;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire
